// ===== rtl/core/was_pkg.sv =====
// Shared types and constants for the weekday alarm scheduler.
`timescale 1ns / 1ps

package was_pkg;

  // Default size of the alarm table.
  localparam int unsigned NumAlarmsDef = 5;

  // Field widths of the item and result beats.
  localparam int unsigned MinuteW = 11;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned DayW    = 3;

  // A mask of exactly this value is a one-shot alarm with no weekdays.
  localparam logic [MaskW-1:0] OneShotMask = 8'h80;

  // Bit of the mask that marks a one-shot alarm.
  localparam int unsigned OneShotBit = 7;

  // Operation codes of an input beat.
  localparam logic OpWrite = 1'b0;
  localparam logic OpCheck = 1'b1;

  // One stored alarm entry.
  typedef struct packed {
    logic [MinuteW-1:0] minute;
    logic [MaskW-1:0]   mask;
  } alarm_entry_t;

endpackage

// ===== rtl/core/weekday_alarm_scheduler_unit.sv =====
// Weekday alarm scheduler: alarm table memory, next-alarm scan and fire logic.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// input    | in        | in_valid_i/in_ready_o  | operation, entry_index/minute/mask,
//          |           |                        | weekday, minute_of_day
// result   | out       | out_valid_o/out_ready_i| fired, one_shot_cleared, pending_valid,
//          |           |                        | pending_slot, wakeup_minute
//
// A write beat goes straight to the result; a check beat first scans the alarm table
// through its single read port, one entry a cycle.
// Reset clears the per-entry valid bits and the pending alarm at once; no clearing pass.
// A new beat is accepted while the previous result still waits in the output register;
// the block only stalls at the end of an item if that register is still full.

module weekday_alarm_scheduler_unit
  import was_pkg::*;
#(
  parameter int unsigned NUM_ALARMS = NumAlarmsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [SlotW-1:0]   entry_index_i,
  input  logic [MinuteW-1:0] entry_minute_i,
  input  logic [MaskW-1:0]   entry_mask_i,
  input  logic [DayW-1:0]    weekday_i,
  input  logic [MinuteW-1:0] minute_of_day_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               fired_o,
  output logic               one_shot_cleared_o,
  output logic               pending_valid_o,
  output logic [SlotW-1:0]   pending_slot_o,
  output logic [MinuteW-1:0] wakeup_minute_o
);

  localparam int unsigned IdxW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_ALARMS - 1);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_LAST   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;

  // Alarm table memory and its per-entry valid bits.
  alarm_entry_t          mem_q [NUM_ALARMS];
  logic [NUM_ALARMS-1:0] valid_q;

  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;
  alarm_entry_t          wr_data;
  logic [IdxW-1:0]       rd_addr;
  alarm_entry_t          rd_data_q;
  logic                  rd_vld_q;
  logic                  rd_ok_q;
  logic [IdxW-1:0]       rd_idx_q;
  alarm_entry_t          rd_entry;

  // Scan and item registers.
  logic [IdxW-1:0]       cnt_q;
  logic [DayW-1:0]       day_q;
  logic [MinuteW-1:0]    now_q;
  logic                  found_q;
  logic [IdxW-1:0]       best_idx_q;
  logic [MinuteW-1:0]    best_min_q;
  alarm_entry_t          pend_data_q;

  // Pending alarm state.
  logic                  pend_q;
  logic [IdxW-1:0]       pend_idx_q;
  logic [MinuteW-1:0]    pend_min_q;

  // Result flags of the current item.
  logic                  res_fired_q;
  logic                  res_cleared_q;

  logic                  in_fire;
  logic                  out_load;
  logic                  idx_in_range;
  logic [7:0]            idx_ext;
  logic [7:0]            pend_ext;
  logic [MaskW-1:0]      day_bit;
  logic                  cand_hit;
  logic                  fire_now;
  logic                  clear_now;

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_fire      = in_valid_i & in_ready_o;
  assign out_load     = (state_q == S_EMIT) && (!out_valid_o || out_ready_i);
  assign idx_ext      = 8'(entry_index_i);
  assign idx_in_range = (32'(entry_index_i) < NUM_ALARMS);
  assign pend_ext     = 8'(pend_idx_q);

  // Entries never written read as all zero: minute 0, all alarms off.
  assign rd_entry = rd_vld_q ? rd_data_q : '0;

  // Candidate test for the entry coming out of the memory this cycle.
  assign day_bit  = MaskW'(1) << day_q;
  assign cand_hit = rd_ok_q
                    && (((rd_entry.mask & day_bit) != '0) || rd_entry.mask[OneShotBit])
                    && (rd_entry.minute > now_q)
                    && (!found_q || (rd_entry.minute < best_min_q));

  // Fire decision at the end of a check.
  assign fire_now  = pend_q && (!found_q || (best_idx_q != pend_idx_q));
  assign clear_now = fire_now && (pend_data_q.mask == OneShotMask);

  // Memory write port: entry writes on accept, one-shot clear on update.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_ext[IdxW-1:0];
    wr_data = '{minute: entry_minute_i, mask: entry_mask_i};
    if (in_fire && (operation_i == OpWrite) && idx_in_range) begin
      wr_en = 1'b1;
    end else if ((state_q == S_UPDATE) && clear_now) begin
      wr_en   = 1'b1;
      wr_addr = pend_idx_q;
      wr_data = '{minute: pend_data_q.minute, mask: '0};
    end
  end

  assign rd_addr = cnt_q;

  // Memory array with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Valid bits and read pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      rd_ok_q  <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      rd_vld_q <= valid_q[rd_addr];
      rd_ok_q  <= (state_q == S_SCAN);
      rd_idx_q <= rd_addr;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (operation_i == OpCheck) ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        if (cnt_q == LastIdx) begin
          state_d = S_LAST;
        end
      end
      S_LAST:   state_d = S_UPDATE;
      S_UPDATE: state_d = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Control state, scan bookkeeping and pending alarm.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      found_q       <= 1'b0;
      pend_q        <= 1'b0;
      pend_idx_q    <= '0;
      pend_min_q    <= '0;
      res_fired_q   <= 1'b0;
      res_cleared_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Start of an item.
      if (in_fire) begin
        cnt_q         <= '0;
        found_q       <= 1'b0;
        res_fired_q   <= 1'b0;
        res_cleared_q <= 1'b0;
        if ((operation_i == OpWrite) && idx_in_range && pend_q
            && (idx_ext[IdxW-1:0] == pend_idx_q)) begin
          pend_min_q <= entry_minute_i;
        end
      end

      // Read address walks the table.
      if ((state_q == S_SCAN) && (cnt_q != LastIdx)) begin
        cnt_q <= cnt_q + IdxW'(1);
      end

      if (cand_hit) begin
        found_q <= 1'b1;
      end

      // Pending alarm update at the end of a check.
      if (state_q == S_UPDATE) begin
        if (!pend_q) begin
          if (found_q) begin
            pend_q     <= 1'b1;
            pend_idx_q <= best_idx_q;
            pend_min_q <= best_min_q;
          end
        end else if (fire_now) begin
          res_fired_q   <= 1'b1;
          res_cleared_q <= clear_now;
          pend_q        <= found_q;
          pend_idx_q    <= found_q ? best_idx_q : '0;
          pend_min_q    <= found_q ? best_min_q : '0;
        end
      end
    end
  end

  // Item payload, best candidate and the pending entry seen during the scan.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      day_q <= weekday_i;
      now_q <= minute_of_day_i;
    end
    if (cand_hit) begin
      best_idx_q <= rd_idx_q;
      best_min_q <= rd_entry.minute;
    end
    if (rd_ok_q && (rd_idx_q == pend_idx_q)) begin
      pend_data_q <= rd_entry;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      fired_o            <= res_fired_q;
      one_shot_cleared_o <= res_cleared_q;
      pending_valid_o    <= pend_q;
      pending_slot_o     <= pend_q ? pend_ext[SlotW-1:0] : '0;
      wakeup_minute_o    <= pend_q ? pend_min_q : '0;
    end
  end

  // The pending alarm always points into the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (32'(pend_idx_q) < NUM_ALARMS))
    else $error("pending index outside the alarm table");

  // A one-shot clear only comes with a fire.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && one_shot_cleared_o) |-> fired_o)
    else $error("one-shot cleared without a fire");

  // With nothing pending the slot and wakeup fields read zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pending_valid_o) |-> ((pending_slot_o == '0) && (wakeup_minute_o == '0)))
    else $error("pending fields not zero without a pending alarm");

  // The update step only follows a full scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) |-> ($past(state_q) == S_LAST))
    else $error("update reached without a completed scan");

endmodule
